@@ rtl/str_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp package
// Shared constants, command codes and the control/status structs that join
// the ramp controller and the ramp datapath.
// ----------------------------------------------------------------------------
package str_pkg;

	// Speed format and tick rate.
	localparam int SPEED_FRAC_BITS  = 12;
	localparam int TICKS_PER_SECOND = 1000;

	// One step per second in the speed format.
	localparam logic [31:0] SPEED_ONE = 32'(64'(1) << SPEED_FRAC_BITS);

	// Division by the tick rate as a multiply by a rounded-up reciprocal.
	// The shift is 32 plus the bit length of the divisor, which makes the
	// quotient exact for every 32-bit dividend.
	localparam int          TICK_LOG    = $clog2(TICKS_PER_SECOND);
	localparam int          RECIP_SHIFT = 32 + TICK_LOG;
	localparam logic [32:0] RECIP       = 33'(((64'(1) << RECIP_SHIFT)
		+ 64'(TICKS_PER_SECOND) - 64'(1)) / 64'(TICKS_PER_SECOND));

	// Shared multiplier operand and product widths.
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// Brake test: the scaled product must stay below 2^64.
	localparam int BRAKE_SHIFT = SPEED_FRAC_BITS + 1;
	localparam int BRAKE_LIM   = 64 - BRAKE_SHIFT;

	// Reload divider: denominator is (prescaler + 1) * max(speed, SPEED_ONE).
	localparam int                 PRESC_W      = 16;
	localparam int                 DEN_W        = PRESC_W + 1 + 32;
	localparam int                 DIV_STEPS    = 32;
	localparam int                 DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	// Stream widths.
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 104;

	// Configuration port.
	localparam int              CFG_IDX_W           = 3;
	localparam int              CFG_DATA_W          = 32;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CORE_CLOCK_HZ   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_PRESCALER = 3'd4;

	// Command codes.
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_TICK     = 2'd0;
	localparam cmd_t CMD_MOVE_ABS = 2'd1;
	localparam cmd_t CMD_MOVE_REL = 2'd2;

	// Operand selection for the shared multiplier.
	typedef enum logic [2:0] {
		MUL_NONE  = 3'd0,
		MUL_SQ    = 3'd1,
		MUL_PR    = 3'd2,
		MUL_DELTA = 3'd3,
		MUL_DEN   = 3'd4
	} mul_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic     load_in;
		logic     decode;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     save_sq;
		logic     cmp;
		logic     upd;
		logic     div_load;
		logic     div_step;
		logic     out_load;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		cmd_t cmd;
		logic moving;
		logic at_target;
		logic div_last;
	} dp_sts_t;

endpackage

@@ rtl/str_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp controller
// Runs decode for each command and, for a stepping tick, the brake test,
// speed update and reload division; owns the input and output handshakes.
// ----------------------------------------------------------------------------
module str_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  str_pkg::dp_sts_t  sts,
	output str_pkg::ctl_cmd_t ctl
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DECODE = 11'b000_0000_0010,
		ST_SQ     = 11'b000_0000_0100,
		ST_PR     = 11'b000_0000_1000,
		ST_CMP    = 11'b000_0001_0000,
		ST_DELTA  = 11'b000_0010_0000,
		ST_UPD    = 11'b000_0100_0000,
		ST_DEN    = 11'b000_1000_0000,
		ST_DIVL   = 11'b001_0000_0000,
		ST_DIV    = 11'b010_0000_0000,
		ST_FINISH = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.mul_sel = str_pkg::MUL_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					ctl.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				ctl.decode = 1'b1;
				if (sts.cmd == str_pkg::CMD_TICK && sts.moving && !sts.at_target) begin
					state_d = ST_SQ;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SQ: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = str_pkg::MUL_SQ;
				state_d     = ST_PR;
			end
			ST_PR: begin
				ctl.save_sq = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = str_pkg::MUL_PR;
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				ctl.cmp = 1'b1;
				state_d = ST_DELTA;
			end
			ST_DELTA: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = str_pkg::MUL_DELTA;
				state_d     = ST_UPD;
			end
			ST_UPD: begin
				ctl.upd = 1'b1;
				state_d = ST_DEN;
			end
			ST_DEN: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = str_pkg::MUL_DEN;
				state_d     = ST_DIVL;
			end
			ST_DIVL: begin
				ctl.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// A result is never written over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!m_valid_q || m_axis_tready))
		else $error("result loaded while output register still full");

	// An accepted transaction always enters decode next.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_DECODE))
		else $error("accepted transaction did not reach decode");

	// The division ends on its last step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> (state_q == ST_FINISH))
		else $error("divider did not finish on its last step");

	// A finished result waits while the output stays blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !out_free) |=> (state_q == ST_FINISH && m_valid_q))
		else $error("finished result dropped while output blocked");

endmodule

@@ rtl/str_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp datapath
// Holds the configuration and motion state, a shared multiplier, the brake
// test, the speed update, a restoring reload divider and the result register.
// ----------------------------------------------------------------------------
module str_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [str_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [str_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [str_pkg::IN_DATA_W-1:0]         in_data,
	input  logic [str_pkg::IN_USER_W-1:0]         in_user,
	input  str_pkg::ctl_cmd_t                     ctl,
	output str_pkg::dp_sts_t                      sts,
	output logic [str_pkg::OUT_DATA_W-1:0]        out_data
);

	// Configuration registers.
	logic [31:0]                 max_speed_q;
	logic [31:0]                 accel_rate_q;
	logic [31:0]                 decel_rate_q;
	logic [31:0]                 core_clock_q;
	logic [str_pkg::PRESC_W-1:0] prescaler_q;

	// Motion state.
	logic [31:0] speed_q;
	logic [31:0] position_q;
	logic [31:0] target_q;
	logic        moving_q;
	logic        dir_fwd_q;

	// Per-item working registers.
	str_pkg::cmd_t                   cmd_q;
	logic [31:0]                     arg_q;
	logic [31:0]                     rem_q;
	logic [str_pkg::PROD_W-1:0]      prod_q;
	logic [63:0]                     sq_q;
	logic                            brake_q;
	logic                            pulse_q;
	logic [str_pkg::DEN_W-1:0]       den_q;
	logic [str_pkg::DEN_W:0]         div_rem_q;
	logic [31:0]                     num_q;
	logic [31:0]                     quo_q;
	logic [str_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [str_pkg::OUT_DATA_W-1:0]  out_data_q;

	// Combinational helpers.
	logic [31:0]                 diff_w;
	logic [31:0]                 rem_w;
	logic [31:0]                 dest_w;
	logic [str_pkg::MUL_W-1:0]   mul_a;
	logic [str_pkg::MUL_W-1:0]   mul_b;
	logic                        brake_w;
	logic [31:0]                 delta_w;
	logic [31:0]                 dec_w;
	logic [32:0]                 acc_w;
	logic [31:0]                 vv_w;
	logic [63:0]                 num_w;
	logic [str_pkg::DEN_W:0]     trial_w;
	logic                        ge_w;
	logic [31:0]                 reload_w;

	// Distance to the target as the magnitude of the wrapped difference.
	assign diff_w = target_q - position_q;
	assign rem_w  = diff_w[31] ? (32'd0 - diff_w) : diff_w;
	assign dest_w = (cmd_q == str_pkg::CMD_MOVE_REL) ? (position_q + arg_q) : arg_q;

	// Shared multiplier operand selection.
	always_comb begin
		unique case (ctl.mul_sel)
			str_pkg::MUL_SQ: begin
				mul_a = {1'b0, speed_q};
				mul_b = {1'b0, speed_q};
			end
			str_pkg::MUL_PR: begin
				mul_a = {1'b0, decel_rate_q};
				mul_b = {1'b0, rem_q};
			end
			str_pkg::MUL_DELTA: begin
				mul_a = {1'b0, (brake_q ? decel_rate_q : accel_rate_q)};
				mul_b = str_pkg::RECIP;
			end
			str_pkg::MUL_DEN: begin
				mul_a = str_pkg::MUL_W'(prescaler_q) + str_pkg::MUL_W'(1);
				mul_b = {1'b0, vv_w};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Brake when speed squared reaches twice decel times remaining, scaled.
	assign brake_w = (prod_q[63:str_pkg::BRAKE_LIM] == '0)
		&& (sq_q >= (prod_q[63:0] << str_pkg::BRAKE_SHIFT));

	// Speed change per tick and the two candidate speeds.
	assign delta_w = 32'(prod_q >> str_pkg::RECIP_SHIFT);
	assign dec_w   = (speed_q > delta_w) ? (speed_q - delta_w) : 32'd0;
	assign acc_w   = {1'b0, speed_q} + {1'b0, delta_w};

	// Reload divider operands and one restoring step.
	assign vv_w    = (speed_q < str_pkg::SPEED_ONE) ? str_pkg::SPEED_ONE : speed_q;
	assign num_w   = 64'(core_clock_q) << str_pkg::SPEED_FRAC_BITS;
	assign trial_w = {div_rem_q[str_pkg::DEN_W-1:0], num_q[31]};
	assign ge_w    = (trial_w >= {1'b0, den_q});

	// Reload is quotient minus one, floored at zero, and only on a step.
	assign reload_w = (!pulse_q || quo_q == 32'd0) ? 32'd0 : (quo_q - 32'd1);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= 32'd4096000;
			accel_rate_q <= 32'd4096000;
			decel_rate_q <= 32'd4096000;
			core_clock_q <= 32'd72000000;
			prescaler_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				str_pkg::REG_MAX_SPEED:       max_speed_q  <= cfg_data;
				str_pkg::REG_ACCEL_RATE:      accel_rate_q <= cfg_data;
				str_pkg::REG_DECEL_RATE:      decel_rate_q <= cfg_data;
				str_pkg::REG_CORE_CLOCK_HZ:   core_clock_q <= cfg_data;
				str_pkg::REG_TIMER_PRESCALER: prescaler_q  <= cfg_data[str_pkg::PRESC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Motion state: move commands, stop at target and the stepping update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= '0;
			position_q <= '0;
			target_q   <= '0;
			moving_q   <= 1'b0;
			dir_fwd_q  <= 1'b0;
		end else begin
			if (ctl.decode) begin
				if (cmd_q == str_pkg::CMD_MOVE_ABS || cmd_q == str_pkg::CMD_MOVE_REL) begin
					target_q  <= dest_w;
					moving_q  <= 1'b1;
					dir_fwd_q <= ($signed(dest_w) > $signed(position_q));
				end else if (cmd_q == str_pkg::CMD_TICK && moving_q && target_q == position_q) begin
					moving_q <= 1'b0;
					speed_q  <= '0;
				end
			end
			if (ctl.upd) begin
				if (brake_q) begin
					speed_q <= (dec_w < str_pkg::SPEED_ONE) ? str_pkg::SPEED_ONE : dec_w;
				end else if (speed_q < max_speed_q) begin
					speed_q <= (acc_w > {1'b0, max_speed_q}) ? max_speed_q : acc_w[31:0];
				end
				position_q <= dir_fwd_q ? (position_q + 32'd1) : (position_q - 32'd1);
			end
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= in_user;
			arg_q <= in_data;
		end
		if (ctl.decode) begin
			rem_q   <= rem_w;
			pulse_q <= 1'b0;
		end
		if (ctl.mul_en) begin
			prod_q <= str_pkg::PROD_W'(mul_a) * str_pkg::PROD_W'(mul_b);
		end
		if (ctl.save_sq) begin
			sq_q <= prod_q[63:0];
		end
		if (ctl.cmp) begin
			brake_q <= brake_w;
		end
		if (ctl.upd) begin
			pulse_q <= 1'b1;
		end
		if (ctl.div_load) begin
			den_q     <= prod_q[str_pkg::DEN_W-1:0];
			div_rem_q <= (str_pkg::DEN_W + 1)'(num_w >> 32);
			num_q     <= num_w[31:0];
			cnt_q     <= str_pkg::DIV_CNT_LAST;
		end
		if (ctl.div_step) begin
			div_rem_q <= ge_w ? (trial_w - {1'b0, den_q}) : trial_w;
			quo_q     <= {quo_q[30:0], ge_w};
			num_q     <= {num_q[30:0], 1'b0};
			cnt_q     <= cnt_q - str_pkg::DIV_CNT_W'(1);
		end
		if (ctl.out_load) begin
			out_data_q <= {5'd0, speed_q, moving_q, position_q, reload_w, dir_fwd_q, pulse_q};
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.moving    = moving_q;
	assign sts.at_target = (target_q == position_q);
	assign sts.div_last  = (cnt_q == '0);
	assign out_data      = out_data_q;

endmodule

@@ rtl/stepper_trapezoid_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp
// Step/direction ramp generator: move commands set the target, ticks in motion
// brake or accelerate, emit a step and give the timer reload for the new speed.
// ----------------------------------------------------------------------------
// A stepping tick runs decode, speed square, brake product, brake test, delta
// product, speed update, denominator product, divider load, the 32-step
// restoring reload divider and finish. Move commands, idle ticks and the stop
// at the target go from decode to finish; input waits for the result load.
// Reset clears the motion state and loads the register defaults at once;
// there is no clearing pass.
module stepper_trapezoid_ramp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [str_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [str_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] position_or_steps
	input  logic [str_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] command
	input  logic [str_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] step_pulse, [1] forward, [33:2] reload_value, [65:34] current_position,
	// [66] in_motion, [98:67] current_speed, [103:99] zero
	output logic [str_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	str_pkg::ctl_cmd_t ctl;
	str_pkg::dp_sts_t  sts;

	// Sequencer and handshakes.
	str_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.ctl           (ctl)
	);

	// Arithmetic, state and result register.
	str_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.ctl       (ctl),
		.sts       (sts),
		.out_data  (m_axis_tdata)
	);

endmodule
